[hw/rtl/frx_pkg.sv]
// ----------------------------------------------------------------------------
// frx_pkg
// shared types, codes and the crc-16/x.25 byte step for the frame receiver
// ----------------------------------------------------------------------------
package frx_pkg;

    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END     = 8'd3;

    // configuration reset values
    localparam logic [7:0] START_RST   = 8'hEB;
    localparam logic [7:0] VERSION_RST = 8'h00;
    localparam logic [7:0] LENGTH_RST  = 8'd30;
    localparam logic [7:0] END_RST     = 8'h00;

    // parser phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_VERSION = 4'd1;
    localparam logic [3:0] PH_SESSION = 4'd2;
    localparam logic [3:0] PH_PAD     = 4'd3;
    localparam logic [3:0] PH_CMD     = 4'd4;
    localparam logic [3:0] PH_LENGTH  = 4'd5;
    localparam logic [3:0] PH_SEQ     = 4'd6;
    localparam logic [3:0] PH_APPID   = 4'd7;
    localparam logic [3:0] PH_UAVID   = 4'd8;
    localparam logic [3:0] PH_COMMAND = 4'd9;
    localparam logic [3:0] PH_DATA    = 4'd10;
    localparam logic [3:0] PH_CRC_LO  = 4'd11;
    localparam logic [3:0] PH_CRC_HI  = 4'd12;
    localparam logic [3:0] PH_END     = 4'd13;

    // frame layout
    localparam int APPID_BYTES = 3;
    localparam int UAVID_BYTES = 6;
    localparam int OFF_APPID   = 7;
    localparam int OFF_UAVID   = 10;
    localparam int OFF_COMMAND = 16;
    localparam int OFF_DATA    = 17;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    typedef struct packed {
        logic [7:0] open_code;
        logic [7:0] version_code;
        logic [7:0] length_code;
        logic [7:0] close_code;
    } t_cfg;

    typedef struct packed {
        logic       stored;
        logic [5:0] offset;
        logic [7:0] value;
        logic       frame_ok;
        logic       frame_dropped;
    } t_result;

    // one byte of crc-16/x.25, reflected table-free form
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

[hw/rtl/frx_if.sv]
// ----------------------------------------------------------------------------
// frx channel interfaces
// valid/ready channels for received bytes, parse results and register writes
// ----------------------------------------------------------------------------
interface frx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frx_result_if;
    logic       valid;
    logic       ready;
    logic       stored;
    logic [5:0] offset;
    logic [7:0] value;
    logic       frame_ok;
    logic       frame_dropped;

    modport source (output valid, output stored, output offset, output value,
                    output frame_ok, output frame_dropped, input ready);
    modport sink   (input valid, input stored, input offset, input value,
                    input frame_ok, input frame_dropped, output ready);
endinterface

interface frx_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [frx_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/frx_parse_step.sv]
// ----------------------------------------------------------------------------
// frx_parse_step
// next-state and result logic of the frame parser for one received byte
// ----------------------------------------------------------------------------
module frx_parse_step #(
    parameter int DATA_BYTES = 30,
    parameter int SUB_W      = 5
) (
    input  logic [3:0]       i_phase,
    input  logic [SUB_W-1:0] i_sub,
    input  logic [15:0]      i_crc,
    input  logic [7:0]       i_byte,
    input  frx_pkg::t_cfg    i_cfg,
    output logic [3:0]       o_phase,
    output logic [SUB_W-1:0] o_sub,
    output logic [15:0]      o_crc,
    output frx_pkg::t_result o_result
);
    import frx_pkg::*;

    localparam logic [SUB_W-1:0] APPID_LAST = SUB_W'(APPID_BYTES - 1);
    localparam logic [SUB_W-1:0] UAVID_LAST = SUB_W'(UAVID_BYTES - 1);
    localparam logic [SUB_W-1:0] DATA_LAST  = SUB_W'(DATA_BYTES - 1);
    localparam logic [5:0]       OFF_ENDB   = 6'((OFF_DATA + DATA_BYTES + 2) % 64);

    logic       st;
    logic       drop;
    logic       ok;
    logic [5:0] off;
    logic [3:0] ph;
    logic [SUB_W-1:0] sub;

    always_comb begin
        st   = 1'b0;
        drop = 1'b0;
        ok   = 1'b0;
        off  = 6'd0;
        ph   = i_phase;
        sub  = i_sub;
        unique case (i_phase) inside
            PH_IDLE: begin
                if (i_byte == i_cfg.open_code) begin
                    st = 1'b1;
                    ph = PH_VERSION;
                end
            end
            PH_VERSION: begin
                if (i_byte == i_cfg.version_code) begin
                    st  = 1'b1;
                    off = 6'd1;
                    ph  = PH_SESSION;
                end else begin
                    drop = 1'b1;
                end
            end
            PH_SESSION, PH_PAD, PH_CMD, PH_SEQ: begin
                st  = 1'b1;
                off = {2'b00, i_phase};
                ph  = i_phase + 4'd1;
            end
            PH_LENGTH: begin
                if (i_byte == i_cfg.length_code) begin
                    st  = 1'b1;
                    off = 6'd5;
                    ph  = PH_SEQ;
                end else begin
                    drop = 1'b1;
                end
            end
            PH_APPID: begin
                st  = 1'b1;
                off = 6'(OFF_APPID) + 6'(i_sub);
                sub = i_sub + SUB_W'(1);
                if (i_sub == APPID_LAST) begin
                    sub = '0;
                    ph  = PH_UAVID;
                end
            end
            PH_UAVID: begin
                st  = 1'b1;
                off = 6'(OFF_UAVID) + 6'(i_sub);
                sub = i_sub + SUB_W'(1);
                if (i_sub == UAVID_LAST) begin
                    sub = '0;
                    ph  = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                st  = 1'b1;
                off = 6'(OFF_COMMAND);
                ph  = PH_DATA;
            end
            PH_DATA: begin
                st  = 1'b1;
                off = 6'(OFF_DATA) + 6'(i_sub);
                sub = i_sub + SUB_W'(1);
                if (i_sub == DATA_LAST) begin
                    sub = '0;
                    ph  = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                if (i_byte == i_crc[7:0]) ph = PH_CRC_HI;
                else drop = 1'b1;
            end
            PH_CRC_HI: begin
                if (i_byte == i_crc[15:8]) ph = PH_END;
                else drop = 1'b1;
            end
            PH_END: begin
                if (i_byte == i_cfg.close_code) begin
                    st  = 1'b1;
                    ok  = 1'b1;
                    off = OFF_ENDB;
                    ph  = PH_IDLE;
                end else begin
                    drop = 1'b1;
                end
            end
            default: begin
                drop = 1'b1;
            end
        endcase
        if (drop) begin
            ph  = PH_IDLE;
            sub = '0;
        end
    end

    // start byte reseeds; stored bytes up to the last data byte extend the crc
    always_comb begin
        o_crc = i_crc;
        if (i_phase == PH_IDLE) begin
            if (st) o_crc = crc_step(CRC_SEED, i_byte);
        end else if (st && i_phase != PH_END) begin
            o_crc = crc_step(i_crc, i_byte);
        end
    end

    assign o_phase                = ph;
    assign o_sub                  = sub;
    assign o_result.stored        = st;
    assign o_result.offset        = off;
    assign o_result.value         = st ? i_byte : 8'h00;
    assign o_result.frame_ok      = ok;
    assign o_result.frame_dropped = drop;

endmodule

[hw/rtl/frame_receiver_x25_crc_top.sv]
// ----------------------------------------------------------------------------
// frame_receiver_x25_crc_top
// byte-serial parser for a fixed-layout frame with crc-16/x.25 check
// ----------------------------------------------------------------------------
// takes one received byte per transfer and returns exactly one result per byte.
// frame layout: start, version, session, padding, cmd, length, sequence,
// 3 app-id bytes, 6 vehicle-id bytes, command, DATA_BYTES data bytes, crc low,
// crc high, end (50 bytes at the default). start, version, length and end must
// match the configured codes; the crc (seed 0xffff, no final xor) runs from the
// start byte through the last data byte and the two crc bytes are compared, not
// stored. any mismatch drops the byte, flags frame_dropped and returns to idle.
// a byte is taken every cycle unless the result register stalls with the input
// register full; it sits in the input register while the parse step (crc byte
// step plus phase update) works on it; its result then goes to the output
// register for transfer. the result register holds while the sink
// stalls and the input register still takes one more byte behind it. register
// writes complete in the cycle they are offered and are meant to happen only
// while no byte is in flight.
module frame_receiver_x25_crc_top #(
    parameter int DATA_BYTES = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    frx_byte_if.sink     i_rx,
    frx_result_if.source o_res,
    frx_cfg_if.sink      i_cfg
);
    import frx_pkg::*;

    // sub-index covers the app-id, vehicle-id and data runs
    localparam int SUB_W = $clog2(DATA_BYTES > UAVID_BYTES ? DATA_BYTES : UAVID_BYTES);

    // configuration registers
    t_cfg r_cfg;

    // parser state
    logic [3:0]       r_phase;
    logic [SUB_W-1:0] r_sub;
    logic [15:0]      r_crc;
    logic [3:0]       n_phase;
    logic [SUB_W-1:0] n_sub;
    logic [15:0]      n_crc;

    // input register and result register
    logic    r_s1_valid;
    logic    [7:0] r_s1_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic stall;
    logic rx_take;

    // result register is full and not being taken
    assign stall   = r_out_valid && !o_res.ready;
    // input register frees up whenever it moves forward
    assign i_rx.ready = !r_s1_valid || !stall;
    assign rx_take = i_rx.valid && i_rx.ready;

    frx_parse_step #(
        .DATA_BYTES (DATA_BYTES),
        .SUB_W      (SUB_W)
    ) u_step (
        .i_phase  (r_phase),
        .i_sub    (r_sub),
        .i_crc    (r_crc),
        .i_byte   (r_s1_byte),
        .i_cfg    (r_cfg),
        .o_phase  (n_phase),
        .o_sub    (n_sub),
        .o_crc    (n_crc),
        .o_result (n_out)
    );

    // control, parser state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_phase            <= PH_IDLE;
            r_sub              <= '0;
            r_crc              <= CRC_SEED;
            r_cfg.open_code    <= START_RST;
            r_cfg.version_code <= VERSION_RST;
            r_cfg.length_code  <= LENGTH_RST;
            r_cfg.close_code   <= END_RST;
        end else begin
            if (rx_take) begin
                r_s1_valid <= 1'b1;
            end else if (!stall) begin
                r_s1_valid <= 1'b0;
            end

            if (!stall) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_phase <= n_phase;
                    r_sub   <= n_sub;
                    r_crc   <= n_crc;
                end
            end

            // unknown register indexes are ignored
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_START:   r_cfg.open_code    <= i_cfg.data;
                    CFG_VERSION: r_cfg.version_code <= i_cfg.data;
                    CFG_LENGTH:  r_cfg.length_code  <= i_cfg.data;
                    CFG_END:     r_cfg.close_code   <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rx_take) begin
            r_s1_byte <= i_rx.rx_byte;
        end
        if (!stall && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign i_cfg.ready = 1'b1;

    assign o_res.valid         = r_out_valid;
    assign o_res.stored        = r_out.stored;
    assign o_res.offset        = r_out.offset;
    assign o_res.value         = r_out.value;
    assign o_res.frame_ok      = r_out.frame_ok;
    assign o_res.frame_dropped = r_out.frame_dropped;

endmodule

[bench/frame_receiver_x25_crc_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_receiver_x25_crc_top_tb
// self-checking bench for the byte-serial frame parser with crc-16/x.25 check
// ----------------------------------------------------------------------------
// bytes go in on a valid/ready channel and every accepted byte is run through
// a parser model kept here, which queues the one result that byte must give.
// each result transfer is checked field by field against the oldest queued
// result. stimulus: short header cases, full frames with errors at the checked
// bytes, then random frames (good, corrupted, truncated, noise) under several
// register settings, a stretch with no idling and a long result-side stall
// ----------------------------------------------------------------------------
module frame_receiver_x25_crc_top_tb;
    import frx_pkg::*;

    localparam int DATA_BYTES     = 30;
    localparam int FRAME_LEN      = DATA_BYTES + 20;
    localparam int POS_START      = 0;
    localparam int POS_VERSION    = 1;
    localparam int POS_LENGTH     = 5;
    localparam int POS_CRC        = OFF_DATA + DATA_BYTES;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [15:0]          X25_POLY_REFL  = 16'h8408;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'hA5;

    logic i_clk = 1'b0;
    logic i_rst_n;

    frx_byte_if   rx_ch ();
    frx_result_if res_ch ();
    frx_cfg_if    cfg_ch ();

    frame_receiver_x25_crc_top #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies as the block should hold them
    logic [7:0]  cfg_start   = START_RST;
    logic [7:0]  cfg_version = VERSION_RST;
    logic [7:0]  cfg_length  = LENGTH_RST;
    logic [7:0]  cfg_end     = END_RST;

    // parser state as the block should hold it
    logic [3:0]  fr_phase = PH_IDLE;
    logic [7:0]  fr_sub   = 8'd0;
    logic [15:0] fr_crc   = CRC_SEED;

    t_result     pending_results [$];
    logic [7:0]  frame_bytes [FRAME_LEN];

    int          errors     = 0;
    int          idle_count = 0;
    bit          src_gaps   = 1'b1;
    bit          sink_gaps  = 1'b1;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;

    // bitwise crc-16/x.25, reflected polynomial, no final xor
    function automatic logic [15:0] x25_update(logic [15:0] c, logic [7:0] b);
        c = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ X25_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    // advance the parser by one byte and return the result it must report
    function automatic t_result parse_byte(logic [7:0] b);
        t_result r;
        bit      st;
        bit      ok;
        bit      drop;
        int      off;
        st   = 1'b0;
        ok   = 1'b0;
        drop = 1'b0;
        off  = 0;
        case (fr_phase)
            PH_IDLE: begin
                // anything but the start code is ignored while idle
                if (b == cfg_start) begin
                    fr_crc   = x25_update(CRC_SEED, b);
                    st       = 1'b1;
                    fr_phase = PH_VERSION;
                end
            end
            PH_VERSION: begin
                if (b == cfg_version) begin
                    st = 1'b1; off = 1; fr_phase = PH_SESSION;
                end else begin
                    drop = 1'b1;
                end
            end
            PH_SESSION, PH_PAD, PH_CMD, PH_SEQ: begin
                st = 1'b1; off = int'(fr_phase); fr_phase = fr_phase + 4'd1;
            end
            PH_LENGTH: begin
                if (b == cfg_length) begin
                    st = 1'b1; off = 5; fr_phase = PH_SEQ;
                end else begin
                    drop = 1'b1;
                end
            end
            PH_APPID: begin
                st = 1'b1; off = OFF_APPID + fr_sub; fr_sub = fr_sub + 8'd1;
                if (fr_sub >= APPID_BYTES) begin
                    fr_sub = 8'd0; fr_phase = PH_UAVID;
                end
            end
            PH_UAVID: begin
                st = 1'b1; off = OFF_UAVID + fr_sub; fr_sub = fr_sub + 8'd1;
                if (fr_sub >= UAVID_BYTES) begin
                    fr_sub = 8'd0; fr_phase = PH_COMMAND;
                end
            end
            PH_COMMAND: begin
                st = 1'b1; off = OFF_COMMAND; fr_phase = PH_DATA;
            end
            PH_DATA: begin
                st = 1'b1; off = OFF_DATA + fr_sub; fr_sub = fr_sub + 8'd1;
                if (fr_sub >= DATA_BYTES) begin
                    fr_sub = 8'd0; fr_phase = PH_CRC_LO;
                end
            end
            // crc bytes are compared only, never reported as stored
            PH_CRC_LO: begin
                if (b == fr_crc[7:0]) fr_phase = PH_CRC_HI;
                else drop = 1'b1;
            end
            PH_CRC_HI: begin
                if (b == fr_crc[15:8]) fr_phase = PH_END;
                else drop = 1'b1;
            end
            PH_END: begin
                if (b == cfg_end) begin
                    st = 1'b1; ok = 1'b1; off = POS_CRC + 2; fr_phase = PH_IDLE;
                end else begin
                    drop = 1'b1;
                end
            end
            default: drop = 1'b1;
        endcase
        // crc covers the stored bytes after the start code up to the last data byte
        if (st && off >= 1 && off <= OFF_COMMAND + DATA_BYTES)
            fr_crc = x25_update(fr_crc, b);
        // the mismatching byte is not taken as a new start
        if (drop) begin
            fr_phase = PH_IDLE;
            fr_sub   = 8'd0;
        end
        r.stored        = st;
        r.offset        = st ? 6'(off) : 6'd0;
        r.value         = st ? b : 8'd0;
        r.frame_ok      = ok;
        r.frame_dropped = drop;
        return r;
    endfunction

    task automatic report_field(input string field, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, exp_v, act_v);
            errors++;
        end
    endtask

    // predict on each byte transfer, check each result transfer, watch for hangs
    always @(posedge i_clk) begin
        t_result exp_r;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n === 1'b1 && rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) begin
            pending_results.push_back(parse_byte(rx_ch.rx_byte));
            moved = 1'b1;
        end
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, stored %0h offset %0d value %0h",
                         $time, res_ch.stored, res_ch.offset, res_ch.value);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                report_field("stored", exp_r.stored, res_ch.stored);
                report_field("offset", exp_r.offset, res_ch.offset);
                report_field("value", exp_r.value, res_ch.value);
                report_field("frame_ok", exp_r.frame_ok, res_ch.frame_ok);
                report_field("frame_dropped", exp_r.frame_dropped, res_ch.frame_dropped);
            end
        end
        if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)
            moved = 1'b1;
        idle_count = moved ? 0 : idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("frame_receiver_x25_crc_top_tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls, or a long counted hold when asked
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= !(sink_gaps && $urandom_range(0, 99) < 29);
        end
    end

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while (src_gaps && $urandom_range(0, 99) < 29) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (rx_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    // stop offering bytes and let every queued result come back
    task automatic wait_idle();
        @(negedge i_clk);
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_START:   cfg_start   = val;
            CFG_VERSION: cfg_version = val;
            CFG_LENGTH:  cfg_length  = val;
            CFG_END:     cfg_end     = val;
            default: ;  // unknown index, nothing changes
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] s, input logic [7:0] v,
                                 input logic [7:0] l, input logic [7:0] e);
        write_reg(CFG_START, s);
        write_reg(CFG_VERSION, v);
        write_reg(CFG_LENGTH, l);
        write_reg(CFG_END, e);
    endtask

    // well-formed frame with random content under the current codes
    task automatic build_frame();
        logic [15:0] c;
        c = CRC_SEED;
        foreach (frame_bytes[i]) frame_bytes[i] = 8'($urandom_range(0, 255));
        frame_bytes[POS_START]     = cfg_start;
        frame_bytes[POS_VERSION]   = cfg_version;
        frame_bytes[POS_LENGTH]    = cfg_length;
        for (int i = 0; i < POS_CRC; i++) c = x25_update(c, frame_bytes[i]);
        frame_bytes[POS_CRC]       = c[7:0];
        frame_bytes[POS_CRC + 1]   = c[15:8];
        frame_bytes[FRAME_LEN - 1] = cfg_end;
    endtask

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++) send_byte(frame_bytes[i]);
    endtask

    task automatic send_corrupted(input int pos);
        build_frame();
        frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
        send_frame(FRAME_LEN);
    endtask

    // mix of good, corrupted and truncated frames plus line noise
    task automatic run_traffic(input int frames);
        int pick;
        repeat (frames) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                build_frame();
                send_frame(FRAME_LEN);
            end else if (pick < 80) begin
                send_corrupted($urandom_range(0, FRAME_LEN - 1));
            end else if (pick < 90) begin
                build_frame();
                send_frame($urandom_range(1, FRAME_LEN - 1));
            end else begin
                repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // reset codes: bytes other than the start code are ignored while idle
    task automatic test_idle_bytes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h80);
    endtask

    // header mismatches drop the frame; the dropping byte does not restart it
    task automatic test_header_drops();
        send_byte(cfg_start);
        send_byte(cfg_start);       // bad version that equals the start code
        send_byte(8'h00);           // back to idle, so ignored
        send_byte(cfg_start);
        send_byte(cfg_version);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'hFF);           // bad length byte
        wait_idle();
    endtask

    // good frame, then errors in each compared trailer byte and in the version byte
    task automatic test_frame_checks();
        build_frame();
        send_frame(FRAME_LEN);
        send_corrupted(POS_CRC);
        send_corrupted(POS_CRC + 1);
        send_corrupted(FRAME_LEN - 1);
        send_corrupted(POS_VERSION);
        wait_idle();
    endtask

    // register extremes, a random setting and an unknown index
    task automatic test_settings();
        write_reg(CFG_IDX_UNUSED, 8'($urandom_range(0, 255)));
        apply_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_traffic(7);
        wait_idle();
        apply_setting(8'h00, 8'h00, 8'h00, 8'h00);
        run_traffic(7);
        wait_idle();
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_traffic(7);
        wait_idle();
    endtask

    // back-to-back transfers on both sides
    task automatic test_no_gaps();
        apply_setting(START_RST, VERSION_RST, LENGTH_RST, END_RST);
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        run_traffic(4);
        wait_idle();
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // long result stall fills the block while bytes keep being offered,
    // then the sender waits for every result before the next frame
    task automatic test_backpressure();
        build_frame();
        hold_req = 1'b1;
        send_frame(FRAME_LEN);
        wait_idle();
        build_frame();
        send_frame(FRAME_LEN);
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = 8'h00;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_START;
        cfg_ch.data    = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_header_drops();
        test_frame_checks();
        test_settings();
        test_no_gaps();
        test_backpressure();
        wait_idle();

        if (errors == 0) begin
            $display("frame_receiver_x25_crc_top_tb OK");
        end else begin
            $display("frame_receiver_x25_crc_top_tb NOT OK");
        end
        $finish;
    end

endmodule
